>>> sv/stcr_pkg.sv
// Shared types, constants and helper functions for the cycle replay block.
package stcr_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int HISTORY_DEPTH = 8192;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int SINCE_W       = HIST_AW + 1;
    localparam int GAIN_W        = 17;
    localparam int SMOOTH_W      = 33;
    localparam int CFG_AW        = 2;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_AW       = 1;

    localparam logic [GAIN_W-1:0]  ONE_Q16      = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]  COEFF_RESET  = GAIN_W'(148);
    localparam logic [HIST_AW-1:0] PERIOD_RESET = HIST_AW'(128);
    localparam logic [HIST_AW-1:0] PERIOD_MIN   = HIST_AW'(8);
    localparam logic [HIST_AW-1:0] PERIOD_MAX   = HIST_AW'(HISTORY_DEPTH - 4);
    localparam logic [SINCE_W-1:0] SINCE_MAX    = SINCE_W'(2 * HISTORY_DEPTH - 1);

    // register indexes
    localparam logic [CFG_AW-1:0] REG_TARGET_HARDNESS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_TARGET_MIX      = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SMOOTHING_COEFF = 2'd2;
    localparam logic [CFG_AW-1:0] REG_SYNC_ENABLE     = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic [GAIN_W-1:0] target_hardness;
        logic [GAIN_W-1:0] target_mix;
        logic [GAIN_W-1:0] smoothing_coeff;
    } t_cfg;

    typedef struct packed {
        t_sample            audio_left;
        t_sample            audio_right;
        logic [HIST_AW-1:0] wr_addr;
        logic [HIST_AW-1:0] rd_addr;
        logic               sync_en;
        logic               hist_valid;
    } t_job;

    function automatic logic [GAIN_W-1:0] cap_q16(input logic [GAIN_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic t_sample sat_sample(input logic signed [SAMPLE_BITS+2:0] v);
        logic signed [SAMPLE_BITS+2:0] hi;
        logic signed [SAMPLE_BITS+2:0] lo;
        hi = (SAMPLE_BITS+3)'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
        lo = -hi - (SAMPLE_BITS+3)'(1);
        if (v > hi) return hi[SAMPLE_BITS-1:0];
        if (v < lo) return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

>>> sv/stcr_ram.sv
// Generic simple dual-port RAM with registered read.
module stcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/stcr_front.sv
// Front end: sync edge detection, period tracking and replay address generation.
module stcr_front
    import stcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_sync_en,
    input  logic    i_accept,
    input  t_sample i_audio_left,
    input  t_sample i_audio_right,
    input  t_sample i_sync_left,
    input  t_sample i_sync_right,
    output t_job    o_job
);
    logic [HIST_AW-1:0] r_wp;
    logic               r_wrapped;
    logic [SINCE_W-1:0] r_since;
    logic [HIST_AW-1:0] r_period;
    logic [HIST_AW-1:0] r_cyc;
    logic               r_prev_np;

    logic signed [SAMPLE_BITS:0] sync_sum;
    logic               positive;
    logic               trig;
    logic [HIST_AW-1:0] clamped;
    logic [HIST_AW-1:0] n_period;
    logic [HIST_AW-1:0] cyc_cur;
    logic [HIST_AW-1:0] cyc_inc;
    logic [HIST_AW-1:0] rd_addr;

    always_comb begin
        sync_sum = {i_sync_left[SAMPLE_BITS-1], i_sync_left}
                   + {i_sync_right[SAMPLE_BITS-1], i_sync_right};
        positive = i_sync_en && (sync_sum > 0);
        trig     = positive && r_prev_np;
        if (r_since < SINCE_W'(PERIOD_MIN)) begin
            clamped = PERIOD_MIN;
        end else if (r_since > SINCE_W'(PERIOD_MAX)) begin
            clamped = PERIOD_MAX;
        end else begin
            clamped = r_since[HIST_AW-1:0];
        end
        n_period = (trig && r_since > SINCE_W'(1)) ? clamped : r_period;
        cyc_cur  = trig ? '0 : r_cyc;
        cyc_inc  = cyc_cur + HIST_AW'(1);
        rd_addr  = r_wp - n_period + cyc_cur;
    end

    assign o_job.audio_left  = i_audio_left;
    assign o_job.audio_right = i_audio_right;
    assign o_job.wr_addr     = r_wp;
    assign o_job.rd_addr     = rd_addr;
    assign o_job.sync_en     = i_sync_en;
    // entries beyond the write pointer are unwritten until the first wrap
    assign o_job.hist_valid  = r_wrapped || (rd_addr < r_wp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_since   <= '0;
            r_period  <= PERIOD_RESET;
            r_cyc     <= '0;
            r_prev_np <= 1'b1;
        end else if (i_accept) begin
            r_wp      <= r_wp + HIST_AW'(1);
            r_wrapped <= r_wrapped || (r_wp == HIST_AW'(HISTORY_DEPTH - 1));
            r_prev_np <= !positive;
            r_period  <= n_period;
            r_cyc     <= (cyc_inc == n_period) ? '0 : cyc_inc;
            if (trig) begin
                r_since <= SINCE_W'(1);
            end else if (r_since < SINCE_MAX) begin
                r_since <= r_since + SINCE_W'(1);
            end
        end
    end
endmodule

>>> sv/stcr_fifo.sv
// Short request queue between front and back ends.
module stcr_fifo
    import stcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);
    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_AW:0]   r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) r_wptr <= r_wptr + FIFO_AW'(1);
            if (i_pop && !o_empty) r_rptr <= r_rptr + FIFO_AW'(1);
            r_count <= r_count + (FIFO_AW+1)'(i_push && !o_full)
                       - (FIFO_AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

>>> sv/stcr_back.sv
// Back end: history write/read, gain smoothing, blend and mix, result register.
module stcr_back
    import stcr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_job    i_job,
    input  logic    i_job_empty,
    output logic    o_job_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_sample o_mixed_left,
    output t_sample o_mixed_right
);
    typedef enum logic [2:0] {S_IDLE, S_SMOOTH, S_MUL1, S_MUL2, S_OUT} t_state;

    localparam int PS_W = SMOOTH_W + 1 + GAIN_W + 1;   // smoothing product
    localparam int P1_W = SAMPLE_BITS + 1 + SMOOTH_W + 1;
    localparam int R_W  = SAMPLE_BITS + 2;
    localparam int P2_W = R_W + SMOOTH_W + 1;

    t_state r_state;
    t_job   r_job;
    logic [SMOOTH_W-1:0] r_sh, r_sm;
    logic signed [PS_W-1:0] r_ph, r_pm;
    t_sample r_rep_l, r_rep_r;
    logic signed [P1_W-1:0] r_p1l, r_p1r;
    logic signed [P2_W-1:0] r_p2l, r_p2r;
    logic    r_out_valid;
    t_sample r_out_l, r_out_r;

    logic [2*SAMPLE_BITS-1:0] ram_rdata;
    logic take;
    logic out_load;
    logic signed [SMOOTH_W:0] diff_h, diff_m;
    logic signed [PS_W-1:0] rnd_h, rnd_m;
    logic signed [SMOOTH_W+1:0] new_h, new_m;
    logic signed [P1_W-1:0] rnd1l, rnd1r;
    logic signed [P2_W-1:0] rnd2l, rnd2r;
    logic signed [SAMPLE_BITS+2:0] sum_l, sum_r;

    assign take      = (r_state == S_IDLE) && !i_job_empty;
    assign o_job_pop = take;
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_pop);

    stcr_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (take),
        .i_waddr (i_job.wr_addr),
        .i_wdata ({i_job.audio_left, i_job.audio_right}),
        .i_raddr (i_job.rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        diff_h = $signed({1'b0, cap_q16(i_cfg.target_hardness), 16'b0})
                 - $signed({1'b0, r_sh});
        diff_m = $signed({1'b0, cap_q16(i_cfg.target_mix), 16'b0})
                 - $signed({1'b0, r_sm});
        // round half up, then arithmetic shift
        rnd_h  = (r_ph + PS_W'(32768)) >>> 16;
        rnd_m  = (r_pm + PS_W'(32768)) >>> 16;
        new_h  = $signed({2'b0, r_sh}) + rnd_h[SMOOTH_W+1:0];
        new_m  = $signed({2'b0, r_sm}) + rnd_m[SMOOTH_W+1:0];
        rnd1l  = (r_p1l + P1_W'(64'sd2147483648)) >>> 32;
        rnd1r  = (r_p1r + P1_W'(64'sd2147483648)) >>> 32;
        rnd2l  = (r_p2l + P2_W'(64'sd2147483648)) >>> 32;
        rnd2r  = (r_p2r + P2_W'(64'sd2147483648)) >>> 32;
        sum_l  = (SAMPLE_BITS+3)'(r_job.audio_left) + rnd2l[SAMPLE_BITS+2:0];
        sum_r  = (SAMPLE_BITS+3)'(r_job.audio_right) + rnd2r[SAMPLE_BITS+2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sh        <= '0;
            r_sm        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !i_pop);
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_job   <= i_job;
                        r_ph    <= diff_h * $signed({1'b0, cap_q16(i_cfg.smoothing_coeff)});
                        r_pm    <= diff_m * $signed({1'b0, cap_q16(i_cfg.smoothing_coeff)});
                        r_state <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    r_sh <= new_h[SMOOTH_W-1:0];
                    r_sm <= new_m[SMOOTH_W-1:0];
                    if (!r_job.sync_en) begin
                        r_rep_l <= r_job.audio_left;
                        r_rep_r <= r_job.audio_right;
                    end else if (r_job.hist_valid) begin
                        r_rep_l <= ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                        r_rep_r <= ram_rdata[SAMPLE_BITS-1:0];
                    end else begin
                        r_rep_l <= '0;
                        r_rep_r <= '0;
                    end
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1l <= ((SAMPLE_BITS+1)'(r_rep_l) - (SAMPLE_BITS+1)'(r_job.audio_left))
                             * $signed({1'b0, r_sh});
                    r_p1r <= ((SAMPLE_BITS+1)'(r_rep_r) - (SAMPLE_BITS+1)'(r_job.audio_right))
                             * $signed({1'b0, r_sh});
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // wet - in, at most as large as replay - in
                    r_p2l <= $signed(rnd1l[R_W-1:0]) * $signed({1'b0, r_sm});
                    r_p2r <= $signed(rnd1r[R_W-1:0]) * $signed({1'b0, r_sm});
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_l <= sat_sample(sum_l);
                        r_out_r <= sat_sample(sum_r);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_mixed_left  = r_out_l;
    assign o_mixed_right = r_out_r;
endmodule

>>> sv/sync_triggered_cycle_replay.sv
// The back end handles one stereo item at a time and takes no new one until it has
// loaded the last result, which an unread result holds off. Its sequence per item is
// history access, smoothing update, two chained multiplies, saturation.
// A 2-entry queue decouples the front end; a 1-entry result register holds output.
// Reset is synchronous: counters, gains and config return to reset values;
// history reads as zero until written, tracked by a wrap flag, so no clear pass.
module sync_triggered_cycle_replay
    import stcr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [GAIN_W-1:0]   i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  t_sample             i_audio_left,
    input  t_sample             i_audio_right,
    input  t_sample             i_sync_left,
    input  t_sample             i_sync_right,
    output logic                empty,
    input  logic                pop,
    output t_sample             o_mixed_left,
    output t_sample             o_mixed_right
);
    t_cfg r_cfg;
    logic r_sync_en;
    t_job front_job, q_job;
    logic q_pop, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_hardness <= '0;
            r_cfg.target_mix      <= '0;
            r_cfg.smoothing_coeff <= COEFF_RESET;
            r_sync_en             <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TARGET_HARDNESS: r_cfg.target_hardness <= i_cfg_wdata;
                REG_TARGET_MIX:      r_cfg.target_mix      <= i_cfg_wdata;
                REG_SMOOTHING_COEFF: r_cfg.smoothing_coeff <= i_cfg_wdata;
                REG_SYNC_ENABLE:     r_sync_en             <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    stcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sync_en     (r_sync_en),
        .i_accept      (push && !full),
        .i_audio_left  (i_audio_left),
        .i_audio_right (i_audio_right),
        .i_sync_left   (i_sync_left),
        .i_sync_right  (i_sync_right),
        .o_job         (front_job)
    );

    stcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_full  (full),
        .o_empty (q_empty)
    );

    stcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_job         (q_job),
        .i_job_empty   (q_empty),
        .o_job_pop     (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_mixed_left  (o_mixed_left),
        .o_mixed_right (o_mixed_right)
    );
endmodule

>>> sv/stcr_checker.sv
// Port-level checker for the cycle replay block, bound to the top level.
module stcr_port_checks
    import stcr_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_sample o_mixed_left,
    input t_sample o_mixed_right
);
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_mixed_left) && $stable(o_mixed_right))
        else $error("waiting result changed");
endmodule

bind sync_triggered_cycle_replay stcr_port_checks u_stcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_mixed_left  (o_mixed_left),
    .o_mixed_right (o_mixed_right)
);
